// ===== rtl/tpw_pkg.sv =====
// Package for the temporary page-window slot table.
// Holds sizes, operation and status codes and the controller state type; no dependencies.
package tpw_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 10;
    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned PAGE_SHIFT     = 12;
    localparam int unsigned FRAME_W        = ADDR_W - PAGE_SHIFT;
    localparam int unsigned STATUS_W       = 3;
    localparam int unsigned CFG_DW         = 32;
    localparam int unsigned CFG_AW         = 3;
    localparam logic [CFG_DW-1:0] BASE_RESET = 32'hFFFF_6000;

    // Operation codes of the func field of a request.
    localparam logic FUNC_MAP   = 1'b0;
    localparam logic FUNC_UNMAP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT   = 3'd0,
        STAT_ALLOC = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_REL   = 3'd3,
        STAT_MISS  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UNMAP,
        S_RESP
    } t_state;

endpackage

// ===== rtl/tpw_if.sv =====
// Request and response channel interfaces of the page-window slot table.
// Depends on tpw_pkg for field widths.
interface tpw_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [tpw_pkg::ADDR_W-1:0]    phys_address;
    logic [tpw_pkg::ADDR_W-1:0]    window_address;

    modport source (output valid, func, phys_address, window_address, input ready);
    modport sink   (input valid, func, phys_address, window_address, output ready);
endinterface

interface tpw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tpw_pkg::ADDR_W-1:0]    mapped_address;
    logic [tpw_pkg::STATUS_W-1:0]  status;
    logic                          invalidate;
    logic [tpw_pkg::ADDR_W-1:0]    invalidate_address;

    modport source (output valid, mapped_address, status, invalidate, invalidate_address,
                    input ready);
    modport sink   (input valid, mapped_address, status, invalidate, invalidate_address,
                    output ready);
endinterface

// ===== rtl/tpw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tpw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/temp_page_window_slot_table.sv =====
// Top level of the temporary page-window slot table: controller, slot RAM, APB register.
// Depends on tpw_pkg, tpw_req_if, tpw_rsp_if and tpw_ram.
//
//  channel  | dir | handshake          | contents
//  ---------+-----+--------------------+---------------------------------------------
//  i_req    | in  | valid/ready        | func, phys_address, window_address
//  o_rsp    | out | valid/ready        | mapped_address, status, invalidate(_address)
//  APB      | in  | psel/penable/pready| window_base at byte address 0
//
// A map request walks the slot RAM one slot per cycle through its single read port,
// and a hit on slot k ends the walk early; the result then passes through the response
// state into the output register. An unmap request goes from the unmap state through
// the response state into the output register. The block is ready for the next request
// in the cycle after a response is loaded.
// After reset the block clears the slot RAM, one slot per cycle, and accepts no
// request meanwhile; APB writes are taken at any time.
// One request is in flight at a time. A finished response waits in the output
// register while the next request is accepted; a response stalled behind it holds
// the controller until the output register frees up.
module temp_page_window_slot_table #(
    parameter int unsigned SLOT_COUNT = tpw_pkg::SLOT_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tpw_req_if.sink                     i_req,
    tpw_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpw_pkg::CFG_AW-1:0]  paddr,
    input  logic [tpw_pkg::CFG_DW-1:0]  pwdata,
    output logic [tpw_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int unsigned IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int unsigned AW     = tpw_pkg::ADDR_W;
    localparam int unsigned PS     = tpw_pkg::PAGE_SHIFT;
    localparam int unsigned FW     = tpw_pkg::FRAME_W;
    localparam int unsigned ENT_W  = FW + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);
    localparam logic [FW-1:0]    FR_COUNT = FW'(SLOT_COUNT);

    // Configuration register. Only the page number of the base is used; the full
    // value is kept so that a read returns what was written.
    logic [tpw_pkg::CFG_DW-1:0] r_base;
    logic                       cfg_wr;
    logic                       cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[tpw_pkg::CFG_AW-1] == 1'b0);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? r_base : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= tpw_pkg::BASE_RESET;
        end else if (cfg_wr) begin
            r_base <= pwdata;
        end
    end

    logic [FW-1:0] base_pg;
    assign base_pg = r_base[AW-1:PS];

    // Controller state and per-request registers.
    tpw_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;        // slot counter for clearing and read issue
    logic             r_pvld, n_pvld;      // read data for r_pidx arrives this cycle
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic             r_efound, n_efound;  // an empty slot has been seen in the walk
    logic [IDX_W-1:0] r_eidx, n_eidx;      // lowest empty slot seen so far
    logic [AW-1:0]    r_phys;
    logic [AW-1:0]    r_virt;

    // Result waiting for the output register.
    logic [AW-1:0]    r_res_addr, n_res_addr;
    tpw_pkg::t_status r_res_stat, n_res_stat;
    logic             r_res_inv, n_res_inv;
    logic [AW-1:0]    r_res_iaddr, n_res_iaddr;

    // Output register.
    logic             r_out_vld, n_out_vld;
    logic [AW-1:0]    r_out_addr;
    tpw_pkg::t_status r_out_stat;
    logic             r_out_inv;
    logic [AW-1:0]    r_out_iaddr;

    // Slot RAM: each entry is {present, frame}.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    tpw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic req_fire;
    assign i_req.ready = (r_state == tpw_pkg::S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // Walk decisions on the slot whose data has just come back.
    logic          rd_present;
    logic          rd_hit;
    logic          rd_last;
    logic          any_empty;
    logic [IDX_W-1:0] alloc_idx;
    logic [FW-1:0] hit_pg;
    logic [FW-1:0] alloc_pg;

    assign rd_present = ram_rdata[FW];
    assign rd_hit     = r_pvld && rd_present && (ram_rdata[FW-1:0] == r_phys[AW-1:PS]);
    assign rd_last    = r_pvld && (r_pidx == IDX_LAST);
    assign any_empty  = r_efound || !rd_present;
    assign alloc_idx  = r_efound ? r_eidx : r_pidx;
    assign hit_pg     = base_pg + FW'(r_pidx);
    assign alloc_pg   = base_pg + FW'(alloc_idx);

    // Unmap: the slot index is the page distance from the base, if the address is
    // page-aligned and that distance lies below the slot count. Addresses wrap
    // modulo 2^32 through the subtraction.
    logic [AW-1:0]    um_diff;
    logic             um_hit;
    logic [IDX_W-1:0] um_idx;

    assign um_diff = r_virt - {base_pg, {PS{1'b0}}};
    assign um_hit  = (um_diff[PS-1:0] == '0) && (um_diff[AW-1:PS] < FR_COUNT);
    assign um_idx  = um_diff[PS+IDX_W-1:PS];

    logic out_free;
    assign out_free = !r_out_vld || o_rsp.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpw_pkg::S_CLEAR: begin
                if (r_idx == CNT_LAST) begin
                    n_state = tpw_pkg::S_IDLE;
                end
            end
            tpw_pkg::S_IDLE: begin
                if (req_fire) begin
                    n_state = (i_req.func == tpw_pkg::FUNC_UNMAP) ? tpw_pkg::S_UNMAP
                                                                  : tpw_pkg::S_SCAN;
                end
            end
            tpw_pkg::S_SCAN: begin
                if (rd_hit || rd_last) begin
                    n_state = tpw_pkg::S_RESP;
                end
            end
            tpw_pkg::S_UNMAP: n_state = tpw_pkg::S_RESP;
            tpw_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = tpw_pkg::S_IDLE;
                end
            end
            default: n_state = tpw_pkg::S_CLEAR;
        endcase
    end

    // Datapath and RAM control.
    always_comb begin
        n_idx       = r_idx;
        n_pvld      = 1'b0;
        n_pidx      = r_pidx;
        n_efound    = r_efound;
        n_eidx      = r_eidx;
        n_res_addr  = r_res_addr;
        n_res_stat  = r_res_stat;
        n_res_inv   = r_res_inv;
        n_res_iaddr = r_res_iaddr;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[IDX_W-1:0];
        ram_wdata   = '0;
        ram_raddr   = r_idx[IDX_W-1:0];
        n_out_vld   = r_out_vld && !o_rsp.ready;

        unique case (r_state)
            tpw_pkg::S_CLEAR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + CNT_W'(1);
            end
            tpw_pkg::S_IDLE: begin
                n_idx    = '0;
                n_efound = 1'b0;
            end
            tpw_pkg::S_SCAN: begin
                if (r_idx != CNT_END) begin
                    n_pvld = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end
                if (r_pvld && !rd_present && !r_efound) begin
                    n_efound = 1'b1;
                    n_eidx   = r_pidx;
                end
                if (rd_hit) begin
                    n_res_addr  = {hit_pg, r_phys[PS-1:0]};
                    n_res_stat  = tpw_pkg::STAT_HIT;
                    n_res_inv   = 1'b0;
                    n_res_iaddr = '0;
                    n_pvld      = 1'b0;
                end else if (rd_last) begin
                    n_pvld = 1'b0;
                    if (any_empty) begin
                        ram_we      = 1'b1;
                        ram_waddr   = alloc_idx;
                        ram_wdata   = {1'b1, r_phys[AW-1:PS]};
                        n_res_addr  = {alloc_pg, r_phys[PS-1:0]};
                        n_res_stat  = tpw_pkg::STAT_ALLOC;
                        n_res_inv   = 1'b1;
                        n_res_iaddr = {alloc_pg, {PS{1'b0}}};
                    end else begin
                        n_res_addr  = '0;
                        n_res_stat  = tpw_pkg::STAT_FULL;
                        n_res_inv   = 1'b0;
                        n_res_iaddr = '0;
                    end
                end
            end
            tpw_pkg::S_UNMAP: begin
                n_res_addr = '0;
                if (um_hit) begin
                    ram_we      = 1'b1;
                    ram_waddr   = um_idx;
                    ram_wdata   = '0;
                    n_res_stat  = tpw_pkg::STAT_REL;
                    n_res_inv   = 1'b1;
                    n_res_iaddr = r_virt;
                end else begin
                    n_res_stat  = tpw_pkg::STAT_MISS;
                    n_res_inv   = 1'b0;
                    n_res_iaddr = '0;
                end
            end
            tpw_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tpw_pkg::S_CLEAR;
            r_idx     <= '0;
            r_pvld    <= 1'b0;
            r_efound  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_pvld    <= n_pvld;
            r_efound  <= n_efound;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx      <= n_pidx;
        r_eidx      <= n_eidx;
        r_res_addr  <= n_res_addr;
        r_res_stat  <= n_res_stat;
        r_res_inv   <= n_res_inv;
        r_res_iaddr <= n_res_iaddr;
        if (req_fire) begin
            r_phys <= i_req.phys_address;
            r_virt <= i_req.window_address;
        end
        if (r_state == tpw_pkg::S_RESP && out_free) begin
            r_out_addr  <= r_res_addr;
            r_out_stat  <= r_res_stat;
            r_out_inv   <= r_res_inv;
            r_out_iaddr <= r_res_iaddr;
        end
    end

    assign o_rsp.valid              = r_out_vld;
    assign o_rsp.mapped_address     = r_out_addr;
    assign o_rsp.status             = r_out_stat;
    assign o_rsp.invalidate         = r_out_inv;
    assign o_rsp.invalidate_address = r_out_iaddr;

endmodule

// ===== rtl/tpw_check.sv =====
// Port-level checker for the page-window slot table, bound to the top level.
// Depends on tpw_pkg for status codes and widths.
module tpw_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [tpw_pkg::ADDR_W-1:0]     i_mapped_address,
    input logic [tpw_pkg::STATUS_W-1:0]   i_status,
    input logic                           i_invalidate,
    input logic [tpw_pkg::ADDR_W-1:0]     i_invalidate_address
);

    // A stalled response stays valid and holds its status and addresses.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_mapped_address) && $stable(i_invalidate_address))
        else $error("response changed while stalled");

    // Invalidation is asked for exactly on a new allocation or a release.
    a_inv_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_invalidate == ((i_status == tpw_pkg::STAT_ALLOC)
            || (i_status == tpw_pkg::STAT_REL)))
        else $error("invalidate does not match status");

    // Flushed addresses are whole window pages, and zero when nothing is flushed.
    a_inv_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_invalidate_address[tpw_pkg::PAGE_SHIFT-1:0] == '0)
            && (i_invalidate || i_invalidate_address == '0))
        else $error("bad invalidate address");

    // Only a successful map returns an address.
    a_map_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == tpw_pkg::STAT_FULL || i_status == tpw_pkg::STAT_REL
            || i_status == tpw_pkg::STAT_MISS) |-> i_mapped_address == '0)
        else $error("mapped address set on a failed map or an unmap");

endmodule

bind temp_page_window_slot_table tpw_check u_tpw_check (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_mapped_address     (o_rsp.mapped_address),
    .i_status             (o_rsp.status),
    .i_invalidate         (o_rsp.invalidate),
    .i_invalidate_address (o_rsp.invalidate_address)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the temporary page-window slot table.
// Depends on tpw_pkg, tpw_req_if, tpw_rsp_if and temp_page_window_slot_table;
// a built-in slot-table predictor checks every response in request order.
module testbench;

    // Register byte address of window_base on the APB port.
    localparam logic [tpw_pkg::CFG_AW-1:0] REG_WINDOW_BASE = 3'd0;

    localparam int unsigned  SLOTS       = tpw_pkg::SLOT_COUNT_DEF;
    localparam logic [31:0]  PAGE_BYTES  = 32'h0000_1000;
    localparam int unsigned  SETTLE      = 20;
    localparam int unsigned  DRAIN_LIMIT = 5000;
    localparam int unsigned  CYCLE_LIMIT = 800000;

    typedef struct packed {
        logic [31:0]      mapped_address;
        tpw_pkg::t_status status;
        logic             invalidate;
        logic [31:0]      invalidate_address;
    } t_slot_result;

    logic clk;
    logic rst_n;

    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [tpw_pkg::CFG_AW-1:0] paddr;
    logic [tpw_pkg::CFG_DW-1:0] pwdata;
    logic [tpw_pkg::CFG_DW-1:0] prdata;
    logic                       pready;

    tpw_req_if req_ch ();
    tpw_rsp_if rsp_ch ();

    temp_page_window_slot_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the block: the window register and the slot store.
    logic [31:0] base_shadow;
    logic [19:0] frame_shadow [SLOTS];
    logic        used_shadow  [SLOTS];

    // Responses still owed by the block, oldest first.
    t_slot_result pending_rsp [$];

    int unsigned error_count;
    int unsigned cycle_count;
    bit          quiet;            // no idling on either side while set
    int unsigned rsp_hold_cycles;  // long receiver hold-off, picked up by the receiver

    // Clock with a period of 12 time units.
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Window page of one slot. The low 12 bits of the register never count,
    // and the sum wraps modulo 2^32.
    function automatic logic [31:0] slot_window(input int unsigned slot);
        return {base_shadow[31:12], 12'h000} + 32'(slot) * PAGE_BYTES;
    endfunction

    // Computes the response to one request and updates the slot store the way
    // the block does. A map looks for a hit first, then takes the first empty
    // slot, else reports a full table. An unmap frees the lowest slot whose
    // window page matches exactly, present or not, else reports a miss.
    function automatic t_slot_result predict_window_op(input logic func,
                                                       input logic [31:0] phys,
                                                       input logic [31:0] virt);
        t_slot_result r;
        logic [19:0]  frame;
        logic [11:0]  offset;
        bit           done;
        r      = '{mapped_address: 32'd0, status: tpw_pkg::STAT_FULL, invalidate: 1'b0,
                   invalidate_address: 32'd0};
        frame  = phys[31:12];
        offset = phys[11:0];
        done   = 1'b0;
        if (func == tpw_pkg::FUNC_MAP) begin
            for (int unsigned i = 0; i < SLOTS; i++) begin
                if (!done && used_shadow[i] && frame_shadow[i] == frame) begin
                    r.mapped_address = slot_window(i) | {20'd0, offset};
                    r.status         = tpw_pkg::STAT_HIT;
                    done             = 1'b1;
                end
            end
            for (int unsigned i = 0; i < SLOTS; i++) begin
                if (!done && !used_shadow[i]) begin
                    used_shadow[i]       = 1'b1;
                    frame_shadow[i]      = frame;
                    r.mapped_address     = slot_window(i) | {20'd0, offset};
                    r.status             = tpw_pkg::STAT_ALLOC;
                    r.invalidate         = 1'b1;
                    r.invalidate_address = slot_window(i);
                    done                 = 1'b1;
                end
            end
        end else begin
            r.status = tpw_pkg::STAT_MISS;
            for (int unsigned i = 0; i < SLOTS; i++) begin
                if (!done && slot_window(i) == virt) begin
                    used_shadow[i]       = 1'b0;
                    frame_shadow[i]      = 20'd0;
                    r.status             = tpw_pkg::STAT_REL;
                    r.invalidate         = 1'b1;
                    r.invalidate_address = slot_window(i);
                    done                 = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Sends one request. Inputs change at the falling edge; acceptance is seen
    // at the rising edge. Valid is left high afterwards, so that back-to-back
    // requests never drop it within one time step; an idle burst lowers it.
    task automatic send_request(input logic func, input logic [31:0] phys,
                                input logic [31:0] virt);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid          <= 1'b1;
        req_ch.func           <= func;
        req_ch.phys_address   <= phys;
        req_ch.window_address <= virt;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        pending_rsp.push_back(predict_window_op(func, phys, virt));
    endtask

    task automatic send_map(input logic [31:0] phys);
        send_request(tpw_pkg::FUNC_MAP, phys, $urandom);
    endtask

    task automatic send_unmap(input logic [31:0] virt);
        send_request(tpw_pkg::FUNC_UNMAP, $urandom, virt);
    endtask

    // Stops offering requests and waits until every owed response has come,
    // then lets the block settle before anything touches its register.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write of window_base followed by a read-back. pready is always high,
    // so the write lands at the edge that ends the access cycle.
    task automatic write_window_base(input logic [31:0] value);
        wait_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_WINDOW_BASE;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        base_shadow = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value) begin
            $error("window_base read-back: expected %h, actual %h", value, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Response checker: every accepted response is matched against the
    // oldest prediction, field by field.
    always @(posedge clk) begin
        t_slot_result want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                $error("response with no request outstanding: status %0d", rsp_ch.status);
                error_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.mapped_address !== want.mapped_address) begin
                    $error("mapped_address: expected %h, actual %h",
                           want.mapped_address, rsp_ch.mapped_address);
                    error_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.invalidate !== want.invalidate) begin
                    $error("invalidate: expected %0d, actual %0d",
                           want.invalidate, rsp_ch.invalidate);
                    error_count++;
                end
                if (rsp_ch.invalidate_address !== want.invalidate_address) begin
                    $error("invalidate_address: expected %h, actual %h",
                           want.invalidate_address, rsp_ch.invalidate_address);
                    error_count++;
                end
            end
        end
    end

    // Response receiver. A long hold-off requested by a test is counted here
    // in cycles; otherwise ready drops for random bursts unless the run is
    // in its quiet tail.
    initial begin
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rsp_hold_cycles != 0) begin
                stall           = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 15);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that hangs ends as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("temp_page_window_slot_table test failed");
        $finish;
    end

    // At the reset window base: allocate slot 0, hit it at the last byte of
    // the page, allocate slot 1 with an all-ones address, fill the rest of the
    // table, then see a full table turn a new frame away while a hit on an
    // existing frame still succeeds.
    task automatic test_fill_and_full();
        send_map(32'h0000_0000);
        send_map(32'h0000_0FFF);
        send_map(32'hFFFF_FFFF);
        for (int unsigned i = 2; i < SLOTS; i++) begin
            send_map({20'(i), 12'(i * 32'h111)});
        end
        send_map(32'h1234_5678);
        send_map(32'hFFFF_F123);
    endtask

    // Release paths: a normal release, a second release of the now empty
    // slot (still a release), reuse of the freed slot, misses on an
    // unaligned window address, on zero and below the base, and a release
    // of the top slot.
    task automatic test_release();
        send_unmap(32'hFFFF_9000);
        send_unmap(32'hFFFF_9000);
        send_map(32'hABCD_E001);
        send_unmap(32'hFFFF_9001);
        send_unmap(32'h0000_0000);
        send_unmap(32'hFFFF_F000);
        send_unmap(32'hFFFF_5000);
    endtask

    // An unaligned base whose low bits must be ignored, with the upper slots
    // wrapping past the top of the address space onto page zero.
    task automatic test_unaligned_base_wrap();
        write_window_base(32'hFFFF_BFFF);
        send_map(32'h5555_5AAA);
        send_unmap(32'h0000_0000);
        send_unmap(32'hFFFF_B000);
    endtask

    // Mostly well-formed traffic: maps drawn from a small frame pool so that
    // hits, allocations and a full table all occur, and unmaps of real window
    // pages (and the two pages just past the table) so that slots free up.
    // The rest is full-range noise.
    task automatic run_random_phase(input int unsigned count);
        logic [19:0]  frame_pool [12];
        logic [31:0]  addr;
        int unsigned  pick;
        for (int unsigned i = 0; i < 12; i++) frame_pool[i] = 20'($urandom);
        frame_pool[0] = 20'h00000;
        frame_pool[1] = 20'hFFFFF;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0) begin
                if (pick < 75) addr = {frame_pool[$urandom_range(0, 11)], 12'($urandom)};
                else           addr = $urandom;
                send_map(addr);
            end else begin
                if (pick < 70)      addr = slot_window($urandom_range(0, SLOTS + 1));
                else if (pick < 85) addr = slot_window($urandom_range(0, SLOTS - 1))
                                           | {20'd0, 12'($urandom_range(1, 4095))};
                else                addr = $urandom;
                send_unmap(addr);
            end
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block fills its output register and stalls its input.
    task automatic test_output_stall();
        rsp_hold_cycles = 300;
        run_random_phase(40);
    endtask

    initial begin
        int unsigned drain;
        error_count     = 0;
        quiet           = 1'b0;
        rsp_hold_cycles = 0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid          = 1'b0;
        req_ch.func           = tpw_pkg::FUNC_MAP;
        req_ch.phys_address   = '0;
        req_ch.window_address = '0;
        base_shadow = tpw_pkg::BASE_RESET;
        for (int unsigned i = 0; i < SLOTS; i++) begin
            frame_shadow[i] = 20'd0;
            used_shadow[i]  = 1'b0;
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_fill_and_full();
        test_release();
        test_unaligned_base_wrap();

        write_window_base(32'h0000_0000);
        run_random_phase(400);
        write_window_base(32'hFFFF_F000);
        run_random_phase(400);
        test_output_stall();
        write_window_base({20'($urandom), 12'h000});
        run_random_phase(400);
        write_window_base($urandom);
        run_random_phase(400);

        // Last stretch runs at full rate on both sides.
        write_window_base(tpw_pkg::BASE_RESET);
        quiet = 1'b1;
        run_random_phase(400);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        drain = 0;
        while (pending_rsp.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE) @(posedge clk);
        if (pending_rsp.size() != 0) begin
            $error("%0d responses never arrived", pending_rsp.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("temp_page_window_slot_table test passed");
        end else begin
            $display("temp_page_window_slot_table test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tpw_pkg.sv
rtl/tpw_if.sv
rtl/tpw_ram.sv
rtl/temp_page_window_slot_table.sv
rtl/tpw_check.sv
tb/testbench.sv
